// ----- hw/rtl/lpg_pkg.sv -----
// Shared types and constants of the line pixel generator.
// No dependencies; compiled first.
`default_nettype none

package lpg_pkg;

  // Configuration register file
  localparam int RegBits      = 13;
  localparam int CfgIndexBits = 1;
  localparam logic [CfgIndexBits-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIndexBits-1:0] CfgImageHeight = 1'b1;
  localparam logic [RegBits-1:0] WidthReset  = 13'd640;
  localparam logic [RegBits-1:0] HeightReset = 13'd480;

  // Operation codes of an input item
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // Bit positions in the mode flags
  localparam int ModeBlend = 0;
  localparam int ModeThick = 1;

  // Linear index width of the frame store
  localparam int IndexBits = 24;

  // Attributes that travel with each pixel down the pipeline
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       blend;
    logic       last;
  } pix_attr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpg_if.sv -----
// Valid/ready channel interfaces of the line pixel generator.
// Depends on lpg_pkg for the index width.
`default_nettype none

// Command channel: one item starts or advances a line.
interface lpg_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [7:0]                   red_in;
  logic [7:0]                   green_in;
  logic [7:0]                   blue_in;
  logic                         transparent;
  logic                         thick;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y,
           red_in, green_in, blue_in, transparent, thick,
    input  ready
  );
  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y,
           red_in, green_in, blue_in, transparent, thick,
    output ready
  );
endinterface

// Pixel channel: one item per pixel written to the frame store.
interface lpg_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpg_pkg::IndexBits-1:0] pixel_index;
  logic                          in_image;
  logic [7:0]                    red_out;
  logic [7:0]                    green_out;
  logic [7:0]                    blue_out;
  logic                          blend;
  logic                          last_pixel;

  modport source (
    output valid, pixel_index, in_image, red_out, green_out, blue_out,
           blend, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, in_image, red_out, green_out, blue_out,
           blend, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/line_pixel_generator_core.sv -----
// Top level of the line pixel generator: frame registers, stepper, index pipeline.
// Depends on lpg_pkg, lpg_if, lpg_stepper and lpg_index.
//
//   Channel   Direction  Handshake          Carries
//   cmd       in         valid/ready        start or step item, endpoints, colour, flags
//   pixel     out        valid/ready        linear index, clip flag, colour, blend, last
//   cfg_*     in         write enable only  image_width (index 0), image_height (index 1)
//
// A thin line accepts one item per cycle unless the pixel channel stalls; a thick
// line holds off the next item while its companion pixel waits, since primary and
// companion pixel share the stepper's single output register. The first result of an
// item passes through the stepper register and three index stages to the pixel channel.
// A step item with no line in progress produces no result. Reset clears the valid
// bits and the line-active flag and loads 640 by 480. A stalled pixel channel fills
// the pipeline stage by stage before the command channel drops ready.
`default_nettype none

module line_pixel_generator_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  lpg_in_if.sink                          cmd,
  lpg_out_if.source                       pixel,
  input  logic                            cfg_wen,
  input  logic [lpg_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [lpg_pkg::RegBits-1:0]     cfg_data
);
  import lpg_pkg::*;

  logic [RegBits-1:0]          image_width;
  logic [RegBits-1:0]          image_height;
  logic                        pix_valid;
  logic                        pix_ready;
  logic signed [COORD_BITS:0]  pix_x;
  logic signed [COORD_BITS:0]  pix_y;
  pix_attr_t                   pix_attr;

  // Frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthReset;
      image_height <= HeightReset;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CfgImageWidth:  image_width  <= cfg_data;
        CfgImageHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lpg_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix_ready (pix_ready),
    .pix_valid (pix_valid),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_attr  (pix_attr)
  );

  lpg_index #(
    .COORD_BITS (COORD_BITS)
  ) u_index (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_attr     (pix_attr),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel        (pixel)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_stepper.sv -----
// Bresenham line state and per-item stepping; emits one pixel per cycle while pix_ready holds.
// Depends on lpg_pkg and lpg_in_if.
`default_nettype none

module lpg_stepper #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  lpg_in_if.sink                     cmd,
  input  logic                       pix_ready,
  output logic                       pix_valid,
  output logic signed [COORD_BITS:0] pix_x,
  output logic signed [COORD_BITS:0] pix_y,
  output lpg_pkg::pix_attr_t         pix_attr
);
  import lpg_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int CW = COORD_BITS + 1;  // pixel coordinate, room for the companion
  localparam int EW = COORD_BITS + 2;  // error accumulator

  // Line state
  logic signed [CW-1:0] cur_x, cur_y, cur_x_next, cur_y_next;
  logic [EW-1:0]        error_acc, error_acc_next;
  logic [C-1:0]         steps_left, steps_left_next;
  logic [CW-1:0]        twice_dx, twice_dy, twice_dx_next, twice_dy_next;
  logic                 x_negative, y_negative, x_major;
  logic                 x_negative_next, y_negative_next, x_major_next;
  logic [23:0]          line_colour, line_colour_next;
  logic [1:0]           mode_flags, mode_flags_next;
  logic                 active, active_next;

  // Companion pixel waiting for the output register
  logic                 comp_pending;
  logic signed [CW-1:0] comp_x, comp_y, comp_x_next, comp_y_next;
  logic                 comp_last, comp_last_next;

  logic load_ok, accept, emit, prim_last, thick_next;

  // Start arithmetic
  logic signed [CW-1:0] dx_s, dy_s, dx_n, dy_n;
  logic [C-1:0]         dx_abs, dy_abs, major_len;

  // Step arithmetic
  logic signed [CW-1:0] xs, ys;
  logic [CW-1:0]        twice_major, twice_minor;
  logic [EW-1:0]        err_sum, err_step;
  logic                 minor_step;

  assign load_ok   = !pix_valid || pix_ready;
  assign cmd.ready = load_ok && !comp_pending;
  assign accept    = cmd.valid && cmd.ready;

  // Deltas and direction of a new line
  always_comb begin
    dx_s      = CW'(cmd.end_x) - CW'(cmd.start_x);
    dy_s      = CW'(cmd.end_y) - CW'(cmd.start_y);
    dx_n      = -dx_s;
    dy_n      = -dy_s;
    dx_abs    = dx_s[CW-1] ? dx_n[C-1:0] : dx_s[C-1:0];
    dy_abs    = dy_s[CW-1] ? dy_n[C-1:0] : dy_s[C-1:0];
    major_len = (dx_abs >= dy_abs) ? dx_abs : dy_abs;
  end

  // One step along the major axis; a tie leaves the minor axis alone.
  always_comb begin
    xs          = x_negative ? {CW{1'b1}} : CW'(1);
    ys          = y_negative ? {CW{1'b1}} : CW'(1);
    twice_major = x_major ? twice_dx : twice_dy;
    twice_minor = x_major ? twice_dy : twice_dx;
    err_sum     = error_acc + EW'(twice_minor);
    minor_step  = err_sum > EW'(twice_major);
    err_step    = minor_step ? (err_sum - EW'(twice_major)) : err_sum;
  end

  // Next line state and the pixels the accepted item produces
  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    error_acc_next  = error_acc;
    steps_left_next = steps_left;
    twice_dx_next   = twice_dx;
    twice_dy_next   = twice_dy;
    x_negative_next = x_negative;
    y_negative_next = y_negative;
    x_major_next    = x_major;
    line_colour_next = line_colour;
    mode_flags_next = mode_flags;
    active_next     = active;
    comp_x_next     = cur_x;
    comp_y_next     = cur_y;
    emit            = 1'b0;

    if (accept) begin
      if (cmd.operation == OpStart) begin
        cur_x_next       = CW'(cmd.start_x);
        cur_y_next       = CW'(cmd.start_y);
        x_negative_next  = dx_s[CW-1];
        y_negative_next  = dy_s[CW-1];
        twice_dx_next    = {dx_abs, 1'b0};
        twice_dy_next    = {dy_abs, 1'b0};
        x_major_next     = dx_abs >= dy_abs;
        steps_left_next  = major_len;
        error_acc_next   = EW'(major_len);
        line_colour_next = {cmd.red_in, cmd.green_in, cmd.blue_in};
        mode_flags_next  = {cmd.thick, cmd.transparent};
        active_next      = major_len != '0;
        // The first companion always sits one down and one to the right.
        comp_x_next      = CW'(cmd.start_x) + CW'(1);
        comp_y_next      = CW'(cmd.start_y) + CW'(1);
        emit             = 1'b1;
      end else if (cmd.operation == OpStep && active) begin
        cur_x_next      = (x_major || minor_step) ? (cur_x + xs) : cur_x;
        cur_y_next      = (!x_major || minor_step) ? (cur_y + ys) : cur_y;
        error_acc_next  = err_step;
        steps_left_next = steps_left - C'(1);
        active_next     = steps_left != C'(1);
        comp_x_next     = cur_x_next + ys;
        comp_y_next     = cur_y_next + xs;
        emit            = 1'b1;
      end
    end

    thick_next     = mode_flags_next[ModeThick];
    prim_last      = !active_next && !thick_next;
    comp_last_next = !active_next;
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      active <= active_next;
    end
    cur_x       <= cur_x_next;
    cur_y       <= cur_y_next;
    error_acc   <= error_acc_next;
    steps_left  <= steps_left_next;
    twice_dx    <= twice_dx_next;
    twice_dy    <= twice_dy_next;
    x_negative  <= x_negative_next;
    y_negative  <= y_negative_next;
    x_major     <= x_major_next;
    line_colour <= line_colour_next;
    mode_flags  <= mode_flags_next;
  end

  // Pixel output register and companion holding slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid    <= 1'b0;
      comp_pending <= 1'b0;
    end else if (load_ok) begin
      if (comp_pending) begin
        pix_valid    <= 1'b1;
        comp_pending <= 1'b0;
      end else begin
        pix_valid    <= accept && emit;
        comp_pending <= accept && emit && thick_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (comp_pending) begin
        pix_x          <= comp_x;
        pix_y          <= comp_y;
        pix_attr.red   <= line_colour[23:16];
        pix_attr.green <= line_colour[15:8];
        pix_attr.blue  <= line_colour[7:0];
        pix_attr.blend <= mode_flags[ModeBlend];
        pix_attr.last  <= comp_last;
      end else begin
        pix_x          <= cur_x_next;
        pix_y          <= cur_y_next;
        pix_attr.red   <= line_colour_next[23:16];
        pix_attr.green <= line_colour_next[15:8];
        pix_attr.blue  <= line_colour_next[7:0];
        pix_attr.blend <= mode_flags_next[ModeBlend];
        pix_attr.last  <= prim_last;
        comp_x         <= comp_x_next;
        comp_y         <= comp_y_next;
        comp_last      <= comp_last_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_index.sv -----
// Three-stage pipeline: centring, row multiply, linear index and frame clip.
// Depends on lpg_pkg and lpg_out_if.
`default_nettype none

module lpg_index #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  logic signed [COORD_BITS:0]  pix_x,
  input  logic signed [COORD_BITS:0]  pix_y,
  input  lpg_pkg::pix_attr_t          pix_attr,
  input  logic [lpg_pkg::RegBits-1:0] image_width,
  input  logic [lpg_pkg::RegBits-1:0] image_height,
  lpg_out_if.source                   pixel
);
  import lpg_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int XW = ((CW > RegBits) ? CW : RegBits) + 1;  // centred coordinate
  localparam int PW = XW + RegBits + 1;                     // row offset
  localparam int DW = PW + 1;                               // linear index
  localparam int AW = 2 * RegBits;                          // frame area

  logic adv1, adv2, adv3;
  logic v1, v2, v3;

  logic signed [XW-1:0] ix1, iy1, ix2;
  logic signed [PW-1:0] prod2;
  logic [AW-1:0]        area2;
  pix_attr_t            a1, a2, a3;

  logic signed [DW-1:0] idx;
  logic                 in_frame;
  logic [IndexBits-1:0] index3;
  logic                 inside3;

  // Pipeline advance: a stage moves when it is empty or its successor moves.
  assign adv3      = !v3 || pixel.ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign pix_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= pix_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: shift to image coordinates, halves rounded down.
  always_ff @(posedge clk) begin
    if (adv1) begin
      ix1 <= XW'(pix_x) + $signed({{(XW-RegBits+1){1'b0}}, image_width[RegBits-1:1]});
      iy1 <= XW'(pix_y) + $signed({{(XW-RegBits+1){1'b0}}, image_height[RegBits-1:1]});
      a1  <= pix_attr;
    end
  end

  // Stage 2: row offset and frame area.
  always_ff @(posedge clk) begin
    if (adv2) begin
      ix2   <= ix1;
      prod2 <= PW'(iy1) * PW'($signed({1'b0, image_width}));
      area2 <= AW'(image_width) * AW'(image_height);
      a2    <= a1;
    end
  end

  // Stage 3: linear index, clipped against the area and the index range.
  always_comb begin
    idx      = DW'(ix2) + DW'(prod2);
    in_frame = !idx[DW-1]
            && (idx[DW-2:0] < (DW-1)'(area2))
            && (idx[DW-2:IndexBits] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      index3  <= in_frame ? idx[IndexBits-1:0] : '0;
      inside3 <= in_frame;
      a3      <= a2;
    end
  end

  assign pixel.valid       = v3;
  assign pixel.pixel_index = index3;
  assign pixel.in_image    = inside3;
  assign pixel.red_out     = a3.red;
  assign pixel.green_out   = a3.green;
  assign pixel.blue_out    = a3.blue;
  assign pixel.blend       = a3.blend;
  assign pixel.last_pixel  = a3.last;

endmodule

`default_nettype wire
